// ===== hw/rtl/tftc_pkg.sv =====
`timescale 1ns / 1ps

package tftc_pkg;

	// sizing
	localparam int STACK_DEPTH = 16;
	localparam int COUNT_WIDTH = 16;
	localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
	localparam int ELEM_W      = 16;

	// opener codes held on the nesting stack
	localparam logic [1:0] CODE_ROUND  = 2'd0;
	localparam logic [1:0] CODE_SQUARE = 2'd1;
	localparam logic [1:0] CODE_CURLY  = 2'd2;
	localparam logic [1:0] CODE_QUOTE  = 2'd3;

	// characters with a meaning
	localparam logic [7:0] CHAR_COMMA  = 8'h2C;
	localparam logic [7:0] CHAR_SPACE  = 8'h20;
	localparam logic [7:0] CHAR_TAB    = 8'h09;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_COLON  = 8'h3A;
	localparam logic [7:0] CHAR_QUOTE  = 8'h22;
	localparam logic [7:0] CHAR_LROUND = 8'h28;
	localparam logic [7:0] CHAR_RROUND = 8'h29;
	localparam logic [7:0] CHAR_LSQ    = 8'h5B;
	localparam logic [7:0] CHAR_RSQ    = 8'h5D;
	localparam logic [7:0] CHAR_LCURLY = 8'h7B;
	localparam logic [7:0] CHAR_RCURLY = 8'h7D;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       line_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0]        out_byte;
		logic              is_last;
		logic [ELEM_W-1:0] element_count;
		logic              bracket_error;
	} out_item_t;

	// shift command to every cell of the stack chain
	typedef struct packed {
		logic push;
		logic pop;
	} stk_op_t;

endpackage

// ===== hw/rtl/text_field_tokenizer_counter.sv =====
`timescale 1ns / 1ps

// Text line tokenizer and token counter. One byte request is taken per clock
// while the skid stage is empty and gives one result request; the per-byte
// update (stack-top compare, token registers, count) is combinational. The
// result goes out through an output register backed by a one-entry skid
// stage, so input keeps flowing for one more byte while the output is
// stalled. The nesting stack is a chain of STACK_DEPTH small cells that shift
// down on an opener and up on a matching closer, the top sitting in the first
// cell. element_count and bracket_error are meaningful on the result with
// is_last set and read zero otherwise. The user must write count_zeros with
// cfg_we only while no line is in flight; the block does not enforce this.
module text_field_tokenizer_counter (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  tftc_pkg::in_item_t    in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output tftc_pkg::out_item_t   out_data
);
	import tftc_pkg::*;

	localparam int SAT_W = (COUNT_WIDTH > ELEM_W) ? COUNT_WIDTH : ELEM_W;
	localparam logic [COUNT_WIDTH-1:0] TALLY_MAX = {COUNT_WIDTH{1'b1}};
	localparam logic [ELEM_W-1:0]      ELEM_MAX  = {ELEM_W{1'b1}};

	// line state
	logic                   count_zeros_q;
	logic [DEPTH_W-1:0]     depth_q, depth_n;
	logic                   quote_q, quote_n;
	logic                   space_q, space_n;
	logic [1:0]             tlen_q, tlen_n;
	logic [7:0]             tlast_q, tlast_n;
	logic [7:0]             tprev_q, tprev_n;
	logic                   first_q, first_n;
	logic                   trail_q, trail_n;
	logic [COUNT_WIDTH-1:0] tally_q, tally_n;
	logic                   err_q, err_n;

	// output register and skid stage
	logic      out_valid_q, skid_valid_q;
	out_item_t out_q, skid_q;

	logic      accept;
	logic      take;
	out_item_t result;
	stk_op_t   op_now, op;
	logic [1:0] push_code;
	logic [1:0] cell_code [STACK_DEPTH];
	logic [1:0] top_code;

	// combinational working values
	logic [7:0] b, ob;
	logic       last, sep, clr, fin_old, fin, is_zero, inc;
	logic [1:0] len0, zlen;
	logic [7:0] last0, prev0, zlast, zprev;
	logic       is_opener, is_closer;
	logic [1:0] opener_code, want;
	logic [SAT_W-1:0] tally_ext;

	assign in_ready = !skid_valid_q;
	assign accept   = in_valid && in_ready;
	assign take     = out_valid_q && out_ready;
	assign top_code = cell_code[0];

	// per-byte update
	always_comb begin
		b         = in_data.in_byte;
		last      = in_data.line_end;
		ob        = b;
		sep       = (b == CHAR_COMMA) || (b == CHAR_SPACE) || (b == CHAR_TAB);
		clr       = 1'b0;
		fin_old   = 1'b0;
		fin       = 1'b0;
		inc       = 1'b0;
		len0      = tlen_q;
		last0     = tlast_q;
		prev0     = tprev_q;
		zlen      = tlen_q;
		zlast     = tlast_q;
		zprev     = tprev_q;
		is_zero   = 1'b0;
		is_opener = 1'b0;
		is_closer = 1'b0;
		opener_code = CODE_ROUND;
		want      = CODE_ROUND;
		push_code = CODE_ROUND;
		op_now    = '0;
		depth_n   = depth_q;
		quote_n   = quote_q;
		space_n   = space_q;
		tlen_n    = tlen_q;
		tlast_n   = tlast_q;
		tprev_n   = tprev_q;
		first_n   = first_q;
		trail_n   = trail_q;
		tally_n   = tally_q;
		err_n     = err_q;

		if (!err_q) begin
			// separators only count at top level
			if (depth_q == '0) begin
				if (sep) begin
					ob = CHAR_SPACE;
					if (!space_q) begin
						if (!last) begin
							fin_old = (tlen_q != 2'd0);
							clr     = 1'b1;
						end
						space_n = 1'b1;
					end
				end else if (space_q) begin
					clr     = 1'b1;
					space_n = 1'b0;
				end
			end

			// token shift register
			if (clr) begin
				len0  = 2'd0;
				last0 = 8'd0;
				prev0 = 8'd0;
			end
			tprev_n = last0;
			tlast_n = ob;
			tlen_n  = (len0 == 2'd2) ? 2'd2 : len0 + 2'd1;

			// zero test on the token being finished
			fin = fin_old || last;
			if (last) begin
				zlen  = tlen_n;
				zlast = tlast_n;
				zprev = tprev_n;
			end
			if (zlen == 2'd1) begin
				is_zero = (zlast == CHAR_ZERO);
			end else if (zlen >= 2'd2) begin
				is_zero = (zlast == CHAR_ZERO) && (zprev == CHAR_COLON);
			end
			if (fin) begin
				trail_n = 1'b0;
				if (count_zeros_q || !is_zero) begin
					inc = 1'b1;
				end else if (first_q) begin
					inc     = 1'b1;
					first_n = 1'b0;
				end else begin
					trail_n = 1'b1;
				end
			end

			// bracket and quote nesting
			if (!quote_q) begin
				unique case (b)
					CHAR_QUOTE: begin
						is_opener   = 1'b1;
						opener_code = CODE_QUOTE;
					end
					CHAR_LROUND: begin
						is_opener   = 1'b1;
						opener_code = CODE_ROUND;
					end
					CHAR_LSQ: begin
						is_opener   = 1'b1;
						opener_code = CODE_SQUARE;
					end
					CHAR_LCURLY: begin
						is_opener   = 1'b1;
						opener_code = CODE_CURLY;
					end
					CHAR_RROUND: begin
						is_closer = 1'b1;
						want      = CODE_ROUND;
					end
					CHAR_RSQ: begin
						is_closer = 1'b1;
						want      = CODE_SQUARE;
					end
					CHAR_RCURLY: begin
						is_closer = 1'b1;
						want      = CODE_CURLY;
					end
					default: begin
					end
				endcase
				if (is_opener) begin
					if (depth_q >= DEPTH_W'(STACK_DEPTH)) begin
						err_n = 1'b1;
					end else begin
						push_code   = opener_code;
						op_now.push = 1'b1;
						depth_n     = depth_q + 1'b1;
						if (opener_code == CODE_QUOTE) begin
							quote_n = 1'b1;
						end
					end
				end
				if (is_closer && depth_q != '0) begin
					if (top_code == want) begin
						op_now.pop = 1'b1;
						depth_n    = depth_q - 1'b1;
					end else begin
						err_n = 1'b1;
					end
				end
			end else if (b == CHAR_QUOTE) begin
				if (depth_q != '0) begin
					op_now.pop = 1'b1;
					depth_n    = depth_q - 1'b1;
				end
				quote_n = 1'b0;
			end

			// a left-out zero that ends the line still counts
			if (last && !err_n && trail_n && !count_zeros_q) begin
				inc = 1'b1;
			end
			if (inc && tally_q != TALLY_MAX) begin
				tally_n = tally_q + 1'b1;
			end
		end

		// result of this byte
		tally_ext            = SAT_W'(tally_n);
		result.out_byte      = ob;
		result.is_last       = last;
		result.element_count = '0;
		result.bracket_error = 1'b0;
		if (last) begin
			result.element_count = (tally_ext > SAT_W'(ELEM_MAX)) ? ELEM_MAX
				: ELEM_W'(tally_ext);
			result.bracket_error = err_n;
		end

		// end of line brings back the reset state
		if (last) begin
			depth_n = '0;
			quote_n = 1'b0;
			space_n = 1'b0;
			tlen_n  = 2'd0;
			tlast_n = 8'd0;
			tprev_n = 8'd0;
			first_n = 1'b1;
			trail_n = 1'b0;
			tally_n = '0;
			err_n   = 1'b0;
		end

		op = accept ? op_now : '0;
	end

	// stack chain, top entry in the first cell
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic [1:0] up_code, down_code;
		if (i == 0) begin : g_top
			assign up_code = push_code;
		end else begin : g_mid
			assign up_code = cell_code[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_bottom
			assign down_code = cell_code[i];
		end else begin : g_inner
			assign down_code = cell_code[i+1];
		end
		tftc_stack_cell u_cell (
			.clk       (clk),
			.op        (op),
			.from_up   (up_code),
			.from_down (down_code),
			.code      (cell_code[i])
		);
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_zeros_q <= 1'b0;
		end else if (cfg_we) begin
			count_zeros_q <= cfg_wdata;
		end
	end

	// line state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			quote_q <= 1'b0;
			space_q <= 1'b0;
			tlen_q  <= 2'd0;
			tlast_q <= 8'd0;
			tprev_q <= 8'd0;
			first_q <= 1'b1;
			trail_q <= 1'b0;
			tally_q <= '0;
			err_q   <= 1'b0;
		end else if (accept) begin
			depth_q <= depth_n;
			quote_q <= quote_n;
			space_q <= space_n;
			tlen_q  <= tlen_n;
			tlast_q <= tlast_n;
			tprev_q <= tprev_n;
			first_q <= first_n;
			trail_q <= trail_n;
			tally_q <= tally_n;
			err_q   <= err_n;
		end
	end

	// output register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (take) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= accept;
				end
			end else if (accept) begin
				if (out_valid_q) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && skid_valid_q) begin
			out_q <= skid_q;
		end else if (accept && (take || !out_valid_q)) begin
			out_q <= result;
		end
		if (accept && out_valid_q && !take) begin
			skid_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// checks
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid stage holds a result while the output register is empty");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_W'(STACK_DEPTH))
		else $error("nesting depth beyond stack size");

	a_quote_on_top: assert property (@(posedge clk) disable iff (!arst_n)
		quote_q |-> (depth_q != '0 && top_code == CODE_QUOTE))
		else $error("quote mode without a quote on the stack top");

	a_line_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_data.line_end) |=> (depth_q == '0 && !err_q && tally_q == '0))
		else $error("line state not cleared after the last byte");

	a_count_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.is_last) |->
			(out_q.element_count == '0 && !out_q.bracket_error))
		else $error("count or error shown on a byte that does not end the line");

endmodule

// ===== hw/rtl/tftc_stack_cell.sv =====
`timescale 1ns / 1ps

module tftc_stack_cell (
	input  logic            clk,
	input  tftc_pkg::stk_op_t op,
	input  logic [1:0]      from_up,
	input  logic [1:0]      from_down,
	output logic [1:0]      code
);
	import tftc_pkg::*;

	logic [1:0] code_q;

	// push takes the entry above, pop takes the entry below
	always_ff @(posedge clk) begin
		if (op.push) begin
			code_q <= from_up;
		end else if (op.pop) begin
			code_q <= from_down;
		end
	end

	assign code = code_q;

endmodule
